[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL; included by fifo_mutex_lock_manager_unit.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

[hw/rtl/fmlm_pkg.sv]
// Types and codes for the queued mutex with FIFO hand-off.
// No dependencies.
`default_nettype none
package fmlm_pkg;

  localparam logic [2:0] OP_LOCK      = 3'd0;
  localparam logic [2:0] OP_TRYLOCK   = 3'd1;
  localparam logic [2:0] OP_UNLOCK    = 3'd2;
  localparam logic [2:0] OP_LOCK_IF   = 3'd3;
  localparam logic [2:0] OP_UNLOCK_IF = 3'd4;

  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_MISUSE   = 3'd4;
  localparam logic [2:0] ST_HELD     = 3'd5;
  localparam logic [2:0] ST_NOACTION = 3'd6;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] client_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       woken_valid;
    logic [7:0] woken_id;
    logic       owner_held;
    logic [7:0] owner_id;
  } rsp_t;

  // wait list link: more set when an older waiter follows
  typedef struct packed {
    logic       more;
    logic [7:0] nxt;
  } link_t;

endpackage
`default_nettype wire

[hw/rtl/fmlm_link_ram.sv]
// Wait list link store: one write port, one read port, registered read data.
// Depends on fmlm_pkg.
`default_nettype none
module fmlm_link_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   waddr_i,
  input  wire fmlm_pkg::link_t    wdata_i,
  input  wire logic               re_i,
  input  wire logic [AddrW-1:0]   raddr_i,
  output fmlm_pkg::link_t         rdata_o
);

  fmlm_pkg::link_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fifo_mutex_lock_manager_unit.sv]
// Queued mutex with FIFO hand-off: top level, request decode and wait list walk.
// Depends on fmlm_pkg, fmlm_link_ram and assert_macros.svh.
// Steps: wait flag read, then decode; an unlock with waiters then walks L links (at most
// Depth-1), one link read a cycle, to hand over to the oldest. Busy stays high until the result
// word is registered, so the next request waits for it. Reset clears the control registers at
// once, then a pass over all Depth entries clears the wait flags.
`default_nettype none
`include "assert_macros.svh"
module fifo_mutex_lock_manager_unit #(
  parameter int unsigned NUM_WAITERS = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire fmlm_pkg::req_t req_i,
  output logic                done_o,
  output fmlm_pkg::rsp_t      rsp_o
);

  localparam int unsigned Depth = (NUM_WAITERS > 256) ? 256 : NUM_WAITERS;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DECODE, S_WALK} state_e;

  state_e             state_q, state_d;
  logic               own_vld_q, own_vld_d;
  logic [7:0]         own_q, own_d;
  logic               q_ne_q, q_ne_d;
  logic [7:0]         head_q, head_d;
  fmlm_pkg::req_t     req_q, req_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [AddrW-1:0]   cur_q, cur_d;
  logic [AddrW-1:0]   prev_q, prev_d;
  logic               has_prev_q, has_prev_d;
  logic               done_d;
  fmlm_pkg::rsp_t     rsp_d;

  logic               wait_mem [Depth];
  logic               wait_rd_q;
  logic               wait_we, wait_wd;
  logic [AddrW-1:0]   wait_waddr;

  logic               acc, id_ok, mine, waiting, nx_ok, fin;
  logic [2:0]         op, st;
  logic [7:0]         id;
  logic [AddrW-1:0]   a, acc_a;
  logic               woke_v;
  logic [7:0]         woke_id;
  logic               we, re;
  logic [AddrW-1:0]   waddr, raddr;
  fmlm_pkg::link_t    wdata, lk;

  assign acc     = start && !busy;
  assign acc_a   = req_i.client_id[AddrW-1:0];
  assign op      = req_q.operation;
  assign id      = req_q.client_id;
  assign id_ok   = 32'(id) < NUM_WAITERS;
  assign a       = id[AddrW-1:0];
  assign waiting = wait_rd_q;
  assign mine    = own_vld_q && (own_q == id);
  assign nx_ok   = 32'(lk.nxt) < NUM_WAITERS;
  assign busy    = (state_q != S_IDLE);

  fmlm_link_ram #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (lk)
  );

  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[wait_waddr] <= wait_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      wait_rd_q <= wait_mem[acc_a];
    end
  end

  always_comb begin
    state_d    = state_q;
    own_vld_d  = own_vld_q;
    own_d      = own_q;
    q_ne_d     = q_ne_q;
    head_d     = head_q;
    req_d      = req_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    done_d     = 1'b0;
    rsp_d      = rsp_o;
    st         = fmlm_pkg::ST_NOACTION;
    woke_v     = 1'b0;
    woke_id    = 8'd0;
    we         = 1'b0;
    waddr      = a;
    wdata      = '0;
    re         = 1'b0;
    raddr      = head_q[AddrW-1:0];
    wait_we    = 1'b0;
    wait_waddr = a;
    wait_wd    = 1'b0;
    fin        = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        wait_we    = 1'b1;
        wait_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          req_d   = req_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        if (op > fmlm_pkg::OP_UNLOCK_IF) begin
          st = fmlm_pkg::ST_NOACTION;
        end else if (!id_ok) begin
          st = fmlm_pkg::ST_MISUSE;
        end else begin
          case (op) inside
            fmlm_pkg::OP_LOCK, fmlm_pkg::OP_LOCK_IF: begin
              if (op == fmlm_pkg::OP_LOCK_IF && mine) begin
                st = fmlm_pkg::ST_HELD;
              end else if (waiting) begin
                st = fmlm_pkg::ST_MISUSE;
              end else if (!own_vld_q) begin
                own_vld_d = 1'b1;
                own_d     = id;
                st        = fmlm_pkg::ST_GRANTED;
              end else if (own_q == id) begin
                st = fmlm_pkg::ST_MISUSE;
              end else begin
                we         = 1'b1;
                wdata.more = q_ne_q;
                wdata.nxt  = q_ne_q ? head_q : 8'd0;
                head_d     = id;
                q_ne_d     = 1'b1;
                wait_we    = 1'b1;
                wait_wd    = 1'b1;
                st         = fmlm_pkg::ST_QUEUED;
              end
            end
            fmlm_pkg::OP_TRYLOCK: begin
              if (waiting) begin
                st = fmlm_pkg::ST_MISUSE;
              end else if (own_vld_q) begin
                st = fmlm_pkg::ST_BUSY;
              end else begin
                own_vld_d = 1'b1;
                own_d     = id;
                st        = fmlm_pkg::ST_GRANTED;
              end
            end
            default: begin
              if (!mine) begin
                st = (op == fmlm_pkg::OP_UNLOCK) ? fmlm_pkg::ST_MISUSE
                                                 : fmlm_pkg::ST_NOACTION;
              end else if (!q_ne_q) begin
                own_vld_d = 1'b0;
                own_d     = 8'd0;
                st        = fmlm_pkg::ST_RELEASED;
              end else begin
                fin        = 1'b0;
                re         = 1'b1;
                cur_d      = head_q[AddrW-1:0];
                has_prev_d = 1'b0;
                state_d    = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if (lk.more && nx_ok) begin
          re         = 1'b1;
          raddr      = lk.nxt[AddrW-1:0];
          prev_d     = cur_q;
          has_prev_d = 1'b1;
          cur_d      = lk.nxt[AddrW-1:0];
        end else begin
          // oldest waiter found: unlink it and hand over
          fin        = 1'b1;
          waddr      = prev_q;
          we         = has_prev_q;
          if (!has_prev_q) begin
            q_ne_d = 1'b0;
          end
          wait_we    = 1'b1;
          wait_waddr = cur_q;
          wait_wd    = 1'b0;
          own_vld_d  = 1'b1;
          own_d      = 8'(cur_q);
          woke_v     = 1'b1;
          woke_id    = 8'(cur_q);
          st         = fmlm_pkg::ST_RELEASED;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      done_d            = 1'b1;
      rsp_d.status      = st;
      rsp_d.woken_valid = woke_v;
      rsp_d.woken_id    = woke_id;
      rsp_d.owner_held  = own_vld_d;
      rsp_d.owner_id    = own_vld_d ? own_d : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      own_vld_q  <= 1'b0;
      own_q      <= 8'd0;
      q_ne_q     <= 1'b0;
      head_q     <= 8'd0;
      req_q      <= '0;
      clr_q      <= '0;
      has_prev_q <= 1'b0;
      done_o     <= 1'b0;
      rsp_o      <= '0;
    end else begin
      state_q    <= state_d;
      own_vld_q  <= own_vld_d;
      own_q      <= own_d;
      q_ne_q     <= q_ne_d;
      head_q     <= head_d;
      req_q      <= req_d;
      clr_q      <= clr_d;
      has_prev_q <= has_prev_d;
      done_o     <= done_d;
      rsp_o      <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
  end

  `ASSERT_RST(a_walk_ends_in_word, clk_i, rst_ni, ($fell(busy) && $past(state_q) != S_CLEAR) |-> done_o)
  `ASSERT_RST(a_wake_consistent, clk_i, rst_ni, (done_o && rsp_o.woken_valid) |-> (rsp_o.owner_held && rsp_o.owner_id == rsp_o.woken_id))
  `ASSERT_RST(a_single_cycle_word, clk_i, rst_ni, done_o |=> !done_o)
  `ASSERT_RST(a_queue_needs_owner, clk_i, rst_ni, q_ne_q |-> own_vld_q)

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for fifo_mutex_lock_manager_unit: directed and random request words,
// each result word checked against an in-bench mutex and wait-list model.
// Depends on fmlm_pkg and the RTL under hw/rtl.
module tb_top;

  localparam int NUM_W       = 256;
  localparam int RAND_ITEMS  = 1525;
  localparam int STALL_LIMIT = 4000;
  localparam int ERR_PRINT   = 40;

  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  fmlm_pkg::req_t req    = '0;
  logic           busy;
  logic           done_o;
  fmlm_pkg::rsp_t rsp_o;

  fifo_mutex_lock_manager_unit #(.NUM_WAITERS(NUM_W)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial forever #5 clk_i = ~clk_i;

  fmlm_pkg::req_t pending_req[$];
  fmlm_pkg::rsp_t expected_rsp[$];
  int             err_cnt = 0;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= ERR_PRINT) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // mutex model: owner, linked wait list (head is newest), waiting flags
  logic            own_valid;
  logic [7:0]      own_id;
  logic            q_nonempty;
  logic [7:0]      q_head;
  fmlm_pkg::link_t link_mem [NUM_W];
  logic            waiting [NUM_W];

  function automatic logic [2:0] enqueue_waiter(input logic [7:0] id);
    if (waiting[id]) return fmlm_pkg::ST_MISUSE;
    if (!own_valid) begin
      own_valid = 1'b1;
      own_id    = id;
      return fmlm_pkg::ST_GRANTED;
    end
    if (own_id == id) return fmlm_pkg::ST_MISUSE;
    if (q_nonempty) begin
      link_mem[id].more = 1'b1;
      link_mem[id].nxt  = q_head;
    end else begin
      link_mem[id] = '0;
    end
    q_head       = id;
    q_nonempty   = 1'b1;
    waiting[id]  = 1'b1;
    return fmlm_pkg::ST_QUEUED;
  endfunction

  function automatic logic [2:0] hand_off(output logic wv, output logic [7:0] wid);
    logic [7:0] cur;
    logic [7:0] prev;
    logic       has_prev;
    int         steps;
    wv  = 1'b0;
    wid = '0;
    if (!q_nonempty) begin
      own_valid = 1'b0;
      own_id    = '0;
      return fmlm_pkg::ST_RELEASED;
    end
    cur      = q_head;
    prev     = cur;
    has_prev = 1'b0;
    steps    = 1;
    while (steps < NUM_W && link_mem[cur].more) begin
      prev     = cur;
      has_prev = 1'b1;
      cur      = link_mem[cur].nxt;
      steps++;
    end
    if (has_prev) link_mem[prev] = '0;
    else q_nonempty = 1'b0;
    waiting[cur] = 1'b0;
    own_valid    = 1'b1;
    own_id       = cur;
    wv           = 1'b1;
    wid          = cur;
    return fmlm_pkg::ST_RELEASED;
  endfunction

  function automatic fmlm_pkg::rsp_t predict_mutex(input fmlm_pkg::req_t r);
    fmlm_pkg::rsp_t o;
    logic           mine;
    logic           wv;
    logic [7:0]     wid;
    o    = '0;
    wv   = 1'b0;
    wid  = '0;
    mine = own_valid && own_id == r.client_id;
    case (r.operation)
      fmlm_pkg::OP_LOCK: o.status = enqueue_waiter(r.client_id);
      fmlm_pkg::OP_TRYLOCK: begin
        if (waiting[r.client_id]) o.status = fmlm_pkg::ST_MISUSE;
        else if (own_valid) o.status = fmlm_pkg::ST_BUSY;
        else begin
          own_valid = 1'b1;
          own_id    = r.client_id;
          o.status  = fmlm_pkg::ST_GRANTED;
        end
      end
      fmlm_pkg::OP_UNLOCK: begin
        if (mine) o.status = hand_off(wv, wid);
        else o.status = fmlm_pkg::ST_MISUSE;
      end
      fmlm_pkg::OP_LOCK_IF: begin
        if (mine) o.status = fmlm_pkg::ST_HELD;
        else o.status = enqueue_waiter(r.client_id);
      end
      fmlm_pkg::OP_UNLOCK_IF: begin
        if (mine) o.status = hand_off(wv, wid);
        else o.status = fmlm_pkg::ST_NOACTION;
      end
      default: o.status = fmlm_pkg::ST_NOACTION;
    endcase
    o.woken_valid = wv;
    o.woken_id    = wid;
    o.owner_held  = own_valid;
    o.owner_id    = own_valid ? own_id : 8'd0;
    return o;
  endfunction

  task automatic check_word(input fmlm_pkg::rsp_t got);
    fmlm_pkg::rsp_t want;
    if (expected_rsp.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h", got));
      return;
    end
    want = expected_rsp.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.woken_valid !== want.woken_valid)
      report_mismatch($sformatf("woken_valid %b, want %b", got.woken_valid, want.woken_valid));
    if (got.woken_id !== want.woken_id)
      report_mismatch($sformatf("woken_id %0d, want %0d", got.woken_id, want.woken_id));
    if (got.owner_held !== want.owner_held)
      report_mismatch($sformatf("owner_held %b, want %b", got.owner_held, want.owner_held));
    if (got.owner_id !== want.owner_id)
      report_mismatch($sformatf("owner_id %0d, want %0d", got.owner_id, want.owner_id));
  endtask

  // monitor: check results first, then predict the word accepted at this edge
  int stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cnt  <= 0;
      own_valid  = 1'b0;
      own_id     = '0;
      q_nonempty = 1'b0;
      q_head     = '0;
      for (int i = 0; i < NUM_W; i++) begin
        link_mem[i] = '0;
        waiting[i]  = 1'b0;
      end
    end else begin
      if (done_o === 1'b1) check_word(rsp_o);
      if (start && busy === 1'b0) expected_rsp.push_back(predict_mutex(req));
      if (done_o === 1'b1 || (start && busy === 1'b0)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // driver
  int gap_left;
  int quiet_left = 0;

  function automatic int next_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) quiet_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      req      <= '0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_req.size() != 0) begin
        start    <= 1'b1;
        req      <= pending_req.pop_front();
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // stimulus: ownership order kept as a plain queue to steer the sequences
  logic [7:0] owner_line[$];
  logic       in_line [NUM_W];

  task automatic queue_word(input logic [2:0] op, input logic [7:0] id);
    fmlm_pkg::req_t r;
    r.operation = op;
    r.client_id = id;
    pending_req.push_back(r);
    case (op) inside
      fmlm_pkg::OP_LOCK, fmlm_pkg::OP_LOCK_IF: begin
        if (!in_line[id]) begin
          owner_line.push_back(id);
          in_line[id] = 1'b1;
        end
      end
      fmlm_pkg::OP_TRYLOCK: begin
        if (owner_line.size() == 0) begin
          owner_line.push_back(id);
          in_line[id] = 1'b1;
        end
      end
      fmlm_pkg::OP_UNLOCK, fmlm_pkg::OP_UNLOCK_IF: begin
        if (owner_line.size() != 0 && owner_line[0] == id) begin
          void'(owner_line.pop_front());
          in_line[id] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_req.size() != 0 || start || expected_rsp.size() != 0);
  endtask

  initial begin
    int         n_items;
    int         target;
    int         r;
    logic       big_done;
    logic [2:0] op;
    logic [7:0] id;
    for (int i = 0; i < NUM_W; i++) in_line[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_word(fmlm_pkg::OP_LOCK, 8'd0);
    queue_word(fmlm_pkg::OP_LOCK, 8'd0);
    queue_word(fmlm_pkg::OP_TRYLOCK, 8'd0);
    queue_word(fmlm_pkg::OP_LOCK_IF, 8'd0);
    queue_word(fmlm_pkg::OP_TRYLOCK, 8'd255);
    queue_word(fmlm_pkg::OP_LOCK, 8'd255);
    queue_word(fmlm_pkg::OP_LOCK, 8'd255);
    queue_word(fmlm_pkg::OP_TRYLOCK, 8'd255);
    queue_word(fmlm_pkg::OP_LOCK_IF, 8'd255);
    queue_word(fmlm_pkg::OP_LOCK_IF, 8'd170);
    queue_word(fmlm_pkg::OP_UNLOCK, 8'd85);
    queue_word(fmlm_pkg::OP_UNLOCK_IF, 8'd85);
    queue_word(fmlm_pkg::OP_UNLOCK, 8'd255);
    queue_word(OP_RSVD_A, 8'd0);
    queue_word(OP_RSVD_B, 8'd255);
    queue_word(OP_RSVD_C, 8'd170);
    queue_word(fmlm_pkg::OP_UNLOCK, 8'd0);
    queue_word(fmlm_pkg::OP_UNLOCK_IF, 8'd255);
    queue_word(fmlm_pkg::OP_UNLOCK_IF, 8'd170);
    queue_word(fmlm_pkg::OP_UNLOCK, 8'd170);
    queue_word(fmlm_pkg::OP_UNLOCK_IF, 8'd0);
    queue_word(fmlm_pkg::OP_TRYLOCK, 8'd85);
    queue_word(fmlm_pkg::OP_UNLOCK, 8'd85);
    queue_word(fmlm_pkg::OP_LOCK_IF, 8'd255);
    queue_word(fmlm_pkg::OP_UNLOCK_IF, 8'd255);
    wait_drained();

    n_items  = 0;
    target   = 3;
    big_done = 1'b0;
    while (n_items < RAND_ITEMS) begin
      if (owner_line.size() == target) begin
        while (owner_line.size() == target) begin
          if (!big_done && n_items > 300) begin
            target   = NUM_W;
            big_done = 1'b1;
          end else begin
            r = $urandom_range(0, 99);
            if (r < 30) target = 0;
            else if (r < 85) target = $urandom_range(1, 6);
            else target = $urandom_range(7, NUM_W - 1);
          end
        end
        if ($urandom_range(0, 5) == 0) wait_drained();
      end
      if ($urandom_range(0, 99) < 20) begin
        op = 3'($urandom_range(0, 7));
        if (owner_line.size() != 0 && $urandom_range(0, 1) == 1)
          id = owner_line[$urandom_range(0, owner_line.size() - 1)];
        else
          id = 8'($urandom_range(0, 255));
      end else if (owner_line.size() < target) begin
        do id = 8'($urandom_range(0, 255));
        while (in_line[id]);
        r = $urandom_range(0, 2);
        if (r == 0) op = fmlm_pkg::OP_LOCK;
        else if (r == 1) op = fmlm_pkg::OP_LOCK_IF;
        else op = (owner_line.size() == 0) ? fmlm_pkg::OP_TRYLOCK : fmlm_pkg::OP_LOCK;
      end else begin
        id = owner_line[0];
        op = $urandom_range(0, 1) ? fmlm_pkg::OP_UNLOCK : fmlm_pkg::OP_UNLOCK_IF;
      end
      n_items++;
      queue_word(op, id);
    end

    wait_drained();
    repeat (NUM_W + 8) @(negedge clk_i);
    if (expected_rsp.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_rsp.size()));
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fmlm_pkg.sv
hw/rtl/fmlm_link_ram.sv
hw/rtl/fifo_mutex_lock_manager_unit.sv
tb/tb_top.sv
